[design/tksel_pkg.sv]
// ============================================================================
// tksel_pkg
// Shared types and constants of the top-k row selector.
// ============================================================================
`default_nettype none

package tksel_pkg;

    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int ROW_NUM_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_K0_ASC      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_K0_NULLS_1ST = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_K1_ASC      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_K1_NULLS_1ST = 3'd5;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [4:0] limit;
        logic [1:0] key_count;
        logic       k0_asc;
        logic       k0_nulls_first;
        logic       k1_asc;
        logic       k1_nulls_first;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        limit:          5'd16,
        key_count:      2'd1,
        k0_asc:         1'b1,
        k0_nulls_first: 1'b1,
        k1_asc:         1'b1,
        k1_nulls_first: 1'b1
    };

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

[design/tksel_in_if.sv]
// ============================================================================
// tksel_in_if
// Request channel of the top-k row selector: add or finish, row fields.
// ============================================================================
`default_nettype none

interface tksel_in_if #(
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic signed [KEY_WIDTH-1:0]     key0_value;
    logic                            key0_null;
    logic signed [KEY_WIDTH-1:0]     key1_value;
    logic                            key1_null;
    logic        [PAYLOAD_WIDTH-1:0] payload;

    modport source (output valid, kind, key0_value, key0_null, key1_value, key1_null,
                    payload, input ready);
    modport sink   (input valid, kind, key0_value, key0_null, key1_value, key1_null,
                    payload, output ready);
endinterface

`default_nettype wire

[design/tksel_out_if.sv]
// ============================================================================
// tksel_out_if
// Result channel of the top-k row selector: drained rows or an empty marker.
// ============================================================================
`default_nettype none

interface tksel_out_if #(
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
);
    logic                            valid;
    logic                            ready;
    logic signed [KEY_WIDTH-1:0]     out_key0_value;
    logic                            out_key0_null;
    logic signed [KEY_WIDTH-1:0]     out_key1_value;
    logic                            out_key1_null;
    logic        [PAYLOAD_WIDTH-1:0] out_payload;
    logic        [4:0]               row_number;
    logic                            is_empty;
    logic                            last;

    modport source (output valid, out_key0_value, out_key0_null, out_key1_value,
                    out_key1_null, out_payload, row_number, is_empty, last,
                    input ready);
    modport sink   (input valid, out_key0_value, out_key0_null, out_key1_value,
                    out_key1_null, out_payload, row_number, is_empty, last,
                    output ready);
endinterface

`default_nettype wire

[design/top_k_row_selector_unit.sv]
// ============================================================================
// top_k_row_selector_unit
// Keeps the best rows of a group in a sorted chain of cells; a finish
// request drains them in rank order with row numbers, or an empty marker.
// ============================================================================
// Add request: accepted every cycle while idle.
// Finish request: drains min(fill, limit) rows from the head cell, one per
//   cycle into the output register unless it is stalled (an empty marker
//   if none are kept); no request is accepted until the last row is loaded.
// Result: each row is registered in the output register and held until taken.
// Reset: clears fill count, drain state and output valid; config to defaults.
// ============================================================================
`default_nettype none

module top_k_row_selector_unit #(
    parameter int CAPACITY      = 16,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [tksel_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire [tksel_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    tksel_in_if.sink                              i_req,
    tksel_out_if.source                           o_res
);

    localparam int ROW_W = 2 * (KEY_WIDTH + 1) + PAYLOAD_WIDTH;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    tksel_pkg::t_cfg      r_cfg;
    tksel_pkg::t_cell_ctl w_ctl;

    logic             r_state;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    r_emit_idx;
    logic [CW-1:0]    r_emit_n;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [tksel_pkg::ROW_NUM_W-1:0] r_out_num;
    logic             r_out_empty;
    logic             r_out_last;

    logic [CW-1:0]    w_lim;
    logic [CW-1:0]    w_fill_m1;
    logic [CW-1:0]    w_idx_p1;
    logic [CW-1:0]    w_n;
    logic [IW-1:0]    w_pos;
    logic             w_accept;
    logic             w_add;
    logic             w_grow;
    logic             w_load;
    logic [ROW_W-1:0] w_new_row;

    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_c;
    logic [CAPACITY-1:0] w_in_range;
    logic [CAPACITY-1:0] w_is_pos;
    logic [ROW_W-1:0]    w_rows [CAPACITY];

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tksel_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tksel_pkg::CFG_LIMIT:        r_cfg.limit          <= i_cfg_data;
                tksel_pkg::CFG_KEY_COUNT:    r_cfg.key_count      <= i_cfg_data[1:0];
                tksel_pkg::CFG_K0_ASC:       r_cfg.k0_asc         <= i_cfg_data[0];
                tksel_pkg::CFG_K0_NULLS_1ST: r_cfg.k0_nulls_first <= i_cfg_data[0];
                tksel_pkg::CFG_K1_ASC:       r_cfg.k1_asc         <= i_cfg_data[0];
                tksel_pkg::CFG_K1_NULLS_1ST: r_cfg.k1_nulls_first <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- insert control ----------------
    assign w_lim = (32'(r_cfg.limit) > CAPACITY) ? CW'(CAPACITY) : CW'(r_cfg.limit);
    assign w_fill_m1 = r_fill - 1'b1;
    assign w_n = (r_fill < w_lim) ? r_fill : w_lim;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_add    = w_accept && (i_req.kind == tksel_pkg::KIND_ADD);
    assign w_grow   = r_fill < w_lim;

    assign w_new_row = {i_req.key0_null,
                        i_req.key0_null ? {KEY_WIDTH{1'b0}} : i_req.key0_value,
                        i_req.key1_null,
                        i_req.key1_null ? {KEY_WIDTH{1'b0}} : i_req.key1_value,
                        i_req.payload};

    always_comb begin
        w_ctl.ins   = 1'b0;
        w_ctl.shift = w_load;
        w_pos       = r_fill[IW-1:0];
        if (w_add && (w_lim != '0)) begin
            if (w_grow) begin
                w_ctl.ins = 1'b1;
            end else if ((r_fill != '0) && w_lt[w_fill_m1[IW-1:0]]) begin
                w_ctl.ins = 1'b1;
                w_pos     = w_fill_m1[IW-1:0];
            end
        end
    end

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic             w_c_right;
        logic             w_c_left;
        logic [ROW_W-1:0] w_left_row;
        logic [ROW_W-1:0] w_right_row;

        assign w_in_range[g] = w_ctl.ins && (IW'(g) <= w_pos);
        assign w_is_pos[g]   = w_ctl.ins && (IW'(g) == w_pos);

        if (g == CAPACITY - 1) begin : g_tail
            assign w_c_right   = 1'b0;
            assign w_right_row = w_rows[g];
        end else begin : g_mid
            assign w_c_right   = w_c[g+1];
            assign w_right_row = w_rows[g+1];
        end

        if (g == 0) begin : g_head
            assign w_c_left   = 1'b0;
            assign w_left_row = w_new_row;
        end else begin : g_body
            assign w_c_left   = w_c[g-1];
            assign w_left_row = w_rows[g-1];
        end

        tksel_cell #(
            .KEY_WIDTH     (KEY_WIDTH),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
            .ROW_W         (ROW_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cfg       (r_cfg),
            .i_ctl       (w_ctl),
            .i_in_range  (w_in_range[g]),
            .i_is_pos    (w_is_pos[g]),
            .i_c_right   (w_c_right),
            .i_c_left    (w_c_left),
            .i_new_row   (w_new_row),
            .i_left_row  (w_left_row),
            .i_right_row (w_right_row),
            .o_c         (w_c[g]),
            .o_lt        (w_lt[g]),
            .o_row       (w_rows[g])
        );
    end

    // ---------------- drain and output register ----------------
    assign w_load   = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);
    assign w_idx_p1 = r_emit_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_emit_idx  <= '0;
            r_emit_n    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_req.kind == tksel_pkg::KIND_FINISH)) begin
                        r_state    <= ST_EMIT;
                        r_emit_n   <= w_n;
                        r_emit_idx <= '0;
                        r_fill     <= '0;
                    end else if (w_ctl.ins && w_grow) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_emit_idx <= w_idx_p1;
                        if ((r_emit_n == '0) || (w_idx_p1 == r_emit_n)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_emit_n == '0) begin
                r_out_row   <= '0;
                r_out_num   <= '0;
                r_out_empty <= 1'b1;
                r_out_last  <= 1'b1;
            end else begin
                r_out_row   <= w_rows[0];
                r_out_num   <= tksel_pkg::ROW_NUM_W'(w_idx_p1);
                r_out_empty <= 1'b0;
                r_out_last  <= (w_idx_p1 == r_emit_n);
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_key0_null  = r_out_row[ROW_W-1];
    assign o_res.out_key0_value = r_out_row[ROW_W-2 -: KEY_WIDTH];
    assign o_res.out_key1_null  = r_out_row[PAYLOAD_WIDTH+KEY_WIDTH];
    assign o_res.out_key1_value = r_out_row[PAYLOAD_WIDTH +: KEY_WIDTH];
    assign o_res.out_payload    = r_out_row[PAYLOAD_WIDTH-1:0];
    assign o_res.row_number     = r_out_num;
    assign o_res.is_empty       = r_out_empty;
    assign o_res.last           = r_out_last;

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= CAPACITY)
        else $error("fill count above capacity");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_empty) |-> (o_res.last && (o_res.row_number == '0)))
        else $error("empty marker malformed");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.kind == tksel_pkg::KIND_FINISH))
        |=> ((r_state == ST_EMIT) && (r_fill == '0)))
        else $error("finish did not start drain");

    a_drain_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_emit_n != '0)) |-> (r_emit_idx < r_emit_n))
        else $error("drain past kept rows");

endmodule

`default_nettype wire

[design/tksel_cell.sv]
// ============================================================================
// tksel_cell
// One slot of the sorted row chain: compares the offered row with its own,
// takes the offered row or its left neighbor on insert, its right on drain.
// ============================================================================
`default_nettype none

module tksel_cell #(
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int ROW_W         = 2 * (KEY_WIDTH + 1) + PAYLOAD_WIDTH
) (
    input  wire                   i_clk,
    input  wire tksel_pkg::t_cfg      i_cfg,
    input  wire tksel_pkg::t_cell_ctl i_ctl,
    input  wire                   i_in_range,
    input  wire                   i_is_pos,
    input  wire                   i_c_right,
    input  wire                   i_c_left,
    input  wire [ROW_W-1:0]       i_new_row,
    input  wire [ROW_W-1:0]       i_left_row,
    input  wire [ROW_W-1:0]       i_right_row,
    output logic                  o_c,
    output logic                  o_lt,
    output logic [ROW_W-1:0]      o_row
);

    logic [ROW_W-1:0] r_row;
    logic [1:0]       w_ord0;
    logic [1:0]       w_ord1;

    // {decides, a_first}
    function automatic logic [1:0] key_order(
        input logic                        an,
        input logic signed [KEY_WIDTH-1:0] av,
        input logic                        bn,
        input logic signed [KEY_WIDTH-1:0] bv,
        input logic                        asc,
        input logic                        nf
    );
        logic [1:0] res;
        if (an && bn) begin
            res = 2'b00;
        end else if (an) begin
            res = {1'b1, nf};
        end else if (bn) begin
            res = {1'b1, ~nf};
        end else if (av == bv) begin
            res = 2'b00;
        end else begin
            res = {1'b1, asc ? (av < bv) : (av > bv)};
        end
        return res;
    endfunction

    always_comb begin
        w_ord0 = key_order(i_new_row[ROW_W-1], i_new_row[ROW_W-2 -: KEY_WIDTH],
                           r_row[ROW_W-1], r_row[ROW_W-2 -: KEY_WIDTH],
                           i_cfg.k0_asc, i_cfg.k0_nulls_first);
        w_ord1 = key_order(i_new_row[PAYLOAD_WIDTH+KEY_WIDTH],
                           i_new_row[PAYLOAD_WIDTH +: KEY_WIDTH],
                           r_row[PAYLOAD_WIDTH+KEY_WIDTH], r_row[PAYLOAD_WIDTH +: KEY_WIDTH],
                           i_cfg.k1_asc, i_cfg.k1_nulls_first);
        if ((i_cfg.key_count != 2'd0) && w_ord0[1]) begin
            o_lt = w_ord0[0];
        end else if (i_cfg.key_count[1] && w_ord1[1]) begin
            o_lt = w_ord1[0];
        end else begin
            o_lt = 1'b0;
        end
    end

    // set when the offered row lands here or before here
    assign o_c   = i_is_pos | (i_in_range & o_lt & i_c_right);
    assign o_row = r_row;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_row <= i_right_row;
        end else if (i_ctl.ins && o_c) begin
            r_row <= i_c_left ? i_left_row : i_new_row;
        end
    end

endmodule

`default_nettype wire

[dv/tksel_tb_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tksel_tb_pkg
// Request and row types of the top-k selector bench, and a scoreboard that
// tracks the kept rows under the current ordering and checks drained rows.
// ============================================================================
package tksel_tb_pkg;

    import tksel_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        logic               kind;
        logic signed [31:0] k0;
        logic               k0n;
        logic signed [31:0] k1;
        logic               k1n;
        logic        [31:0] pay;
    } req_t;

    typedef struct {
        logic signed [31:0] k0;
        logic               k0n;
        logic signed [31:0] k1;
        logic               k1n;
        logic        [31:0] pay;
    } kept_row_t;

    typedef struct {
        logic signed [31:0] k0;
        logic               k0n;
        logic signed [31:0] k1;
        logic               k1n;
        logic        [31:0] pay;
        logic        [4:0]  row_num;
        logic               empty;
        logic               last;
    } out_row_t;

    class row_scoreboard;
        logic [4:0]  row_limit;
        logic [1:0]  key_count;
        logic        k0_asc;
        logic        k0_nf;
        logic        k1_asc;
        logic        k1_nf;
        kept_row_t   kept [DEPTH];
        int unsigned kept_count;
        out_row_t    rows_due [$];
        int          errors;

        function new();
            row_limit  = 5'd16;
            key_count  = 2'd1;
            k0_asc     = 1'b1;
            k0_nf      = 1'b1;
            k1_asc     = 1'b1;
            k1_nf      = 1'b1;
            kept_count = 0;
            errors     = 0;
        endfunction

        function void write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LIMIT:        row_limit = data[4:0];
                CFG_KEY_COUNT:    key_count = data[1:0];
                CFG_K0_ASC:       k0_asc    = data[0];
                CFG_K0_NULLS_1ST: k0_nf     = data[0];
                CFG_K1_ASC:       k1_asc    = data[0];
                CFG_K1_NULLS_1ST: k1_nf     = data[0];
                default: ;
            endcase
        endfunction

        // 1: a wins, 0: b wins, 2: tie on this key
        function int key_order(logic an, logic signed [31:0] av, logic bn,
                               logic signed [31:0] bv, logic asc, logic nf);
            if (an && bn) return 2;
            if (an) return nf ? 1 : 0;
            if (bn) return nf ? 0 : 1;
            if (av < bv) return asc ? 1 : 0;
            if (av > bv) return asc ? 0 : 1;
            return 2;
        endfunction

        function bit outranks(kept_row_t a, kept_row_t b);
            int nk;
            int r;
            nk = (key_count > 2) ? 2 : int'(key_count);
            if (nk >= 1) begin
                r = key_order(a.k0n, a.k0, b.k0n, b.k0, k0_asc, k0_nf);
                if (r != 2) return r == 1;
            end
            if (nk >= 2) begin
                r = key_order(a.k1n, a.k1, b.k1n, b.k1, k1_asc, k1_nf);
                if (r != 2) return r == 1;
            end
            return 0;
        endfunction

        function void insert_at(int unsigned pos, kept_row_t r);
            while (pos > 0 && outranks(r, kept[pos-1])) begin
                kept[pos] = kept[pos-1];
                pos--;
            end
            kept[pos] = r;
        endfunction

        function void queue_row(out_row_t o);
            rows_due = {rows_due, o};
        endfunction

        function void note_request(req_t q);
            int unsigned lim;
            int unsigned n;
            int unsigned i;
            kept_row_t   r;
            out_row_t    o;
            lim = (row_limit > DEPTH) ? DEPTH : row_limit;
            if (q.kind == KIND_ADD) begin
                r.k0n = q.k0n;
                r.k0  = q.k0n ? '0 : q.k0;
                r.k1n = q.k1n;
                r.k1  = q.k1n ? '0 : q.k1;
                r.pay = q.pay;
                if (lim == 0) return;
                if (kept_count < lim) begin
                    insert_at(kept_count, r);
                    kept_count++;
                end else if (kept_count > 0 && outranks(r, kept[kept_count-1])) begin
                    insert_at(kept_count - 1, r);
                end
                return;
            end
            n = (kept_count < lim) ? kept_count : lim;
            kept_count = 0;
            if (n == 0) begin
                o = '{default: '0};
                o.empty = 1'b1;
                o.last  = 1'b1;
                queue_row(o);
                return;
            end
            for (i = 0; i < n; i++) begin
                o.k0      = kept[i].k0;
                o.k0n     = kept[i].k0n;
                o.k1      = kept[i].k1;
                o.k1n     = kept[i].k1n;
                o.pay     = kept[i].pay;
                o.row_num = 5'(i + 1);
                o.empty   = 1'b0;
                o.last    = (i + 1 == n);
                queue_row(o);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_row(out_row_t got);
            out_row_t want;
            if (rows_due.size() == 0) begin
                $display("%0t: row with nothing expected, row_number %0d payload %h",
                         $time, got.row_num, got.pay);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            compare_field("out_key0_value", want.k0, got.k0);
            compare_field("out_key0_null", want.k0n, got.k0n);
            compare_field("out_key1_value", want.k1, got.k1);
            compare_field("out_key1_null", want.k1n, got.k1n);
            compare_field("out_payload", want.pay, got.pay);
            compare_field("row_number", want.row_num, got.row_num);
            compare_field("is_empty", want.empty, got.empty);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Top-k row selector bench: directed and random add/finish requests under
// changing key orders and limits, random stalls on both channels, drained
// rows checked against a scoreboard that tracks the kept rows.
// ============================================================================
module tb_top;

    import tksel_pkg::*;
    import tksel_tb_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    tksel_in_if  req_if ();
    tksel_out_if res_if ();

    top_k_row_selector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    row_scoreboard sb = new();
    bit calm;
    bit hold_req;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

    always @(posedge i_clk) begin : watch
        out_row_t got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.k0      = res_if.out_key0_value;
            got.k0n     = res_if.out_key0_null;
            got.k1      = res_if.out_key1_value;
            got.k1n     = res_if.out_key1_null;
            got.pay     = res_if.out_payload;
            got.row_num = res_if.row_number;
            got.empty   = res_if.is_empty;
            got.last    = res_if.last;
            sb.check_row(got);
        end
    end

    initial begin : sink_side
        int n;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                res_if.ready = 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val[CFG_DATA_W-1:0];
        sb.write_cfg(idx, val[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_order(input int unsigned lim, input int unsigned kc,
                             input bit a0, input bit n0, input bit a1, input bit n1);
        set_reg(CFG_LIMIT, lim);
        set_reg(CFG_KEY_COUNT, kc);
        set_reg(CFG_K0_ASC, a0);
        set_reg(CFG_K0_NULLS_1ST, n0);
        set_reg(CFG_K1_ASC, a1);
        set_reg(CFG_K1_NULLS_1ST, n1);
    endtask

    // wait for every drained row, then let an in-flight add settle
    task automatic settle();
        while (sb.rows_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send(input req_t q);
        if (!calm && $urandom_range(0, 5) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.kind       = q.kind;
        req_if.key0_value = q.k0;
        req_if.key0_null  = q.k0n;
        req_if.key1_value = q.k1;
        req_if.key1_null  = q.k1n;
        req_if.payload    = q.pay;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(q);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    function automatic req_t add_row(logic [31:0] k0, bit k0n, logic [31:0] k1, bit k1n,
                                     logic [31:0] pay);
        req_t q;
        q.kind = KIND_ADD;
        q.k0   = k0;
        q.k0n  = k0n;
        q.k1   = k1;
        q.k1n  = k1n;
        q.pay  = pay;
        return q;
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rand_req(logic kind);
        req_t q;
        q      = add_row(rand_key(), $urandom_range(0, 5) == 0, rand_key(),
                         $urandom_range(0, 5) == 0, $urandom);
        q.kind = kind;
        return q;
    endfunction

    initial begin : stimulus
        int ph;
        int sent;
        int nrows;
        int i;
        int guard;
        int unsigned lim;
        int unsigned kc;
        req_t fin;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_LIMIT;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_ADD;
        req_if.key0_value = '0;
        req_if.key0_null  = 1'b0;
        req_if.key1_value = '0;
        req_if.key1_null  = 1'b0;
        req_if.payload    = '0;
        calm              = 1'b0;
        hold_req          = 1'b0;
        fin               = add_row('0, 0, '0, 0, '0);
        fin.kind          = KIND_FINISH;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset order: one key, ascending, nulls first; empty group first
        send(fin);
        send(add_row(32'h8000_0000, 0, 32'h7fff_ffff, 0, 32'h0000_0000));
        send(add_row(32'h7fff_ffff, 0, 32'hffff_ffff, 1, 32'hffff_ffff));
        send(add_row(32'h7fff_ffff, 1, 32'hffff_ffff, 0, 32'h0000_0001));
        send(add_row(32'd5, 0, 32'd9, 0, 32'h0000_0002));
        send(add_row(32'd5, 0, 32'd1, 0, 32'h0000_0003));
        send(add_row(32'hffff_ffff, 0, 32'd0, 0, 32'h0000_0004));
        send(add_row(32'd0, 0, 32'd0, 1, 32'h0000_0005));
        send(fin);

        // two keys, first descending nulls last, limit 2: replacement and ties
        settle();
        set_order(2, 2, 0, 0, 1, 1);
        send(add_row(32'd3, 0, 32'd1, 0, 32'h10));
        send(add_row(32'd3, 0, 32'd7, 1, 32'h11));
        send(add_row(32'd7, 0, 32'd0, 0, 32'h12));
        send(add_row(32'd3, 0, 32'd0, 1, 32'h13));
        send(add_row(32'd9, 1, 32'd0, 0, 32'h14));
        send(fin);

        // limit zero keeps nothing
        settle();
        set_reg(CFG_LIMIT, 0);
        send(add_row(32'd1, 0, 32'd1, 0, 32'h20));
        send(fin);

        // limit lowered while rows are kept
        settle();
        set_order(16, 1, 1, 1, 1, 1);
        for (i = 0; i < 5; i++) send(add_row(32'(10 * i), 0, 32'd0, 0, 32'(32'h30 + i)));
        settle();
        set_reg(CFG_LIMIT, 3);
        send(add_row(32'd15, 0, 32'd0, 0, 32'h35));
        send(fin);

        for (ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: set_order(16, 2, 0, 0, 0, 0);
                1: set_order(1, 0, 1, 1, 1, 1);
                2: set_order(31, 3, 1, 1, 1, 1);
                3: set_order(17, 2, $urandom_range(0, 1), $urandom_range(0, 1),
                             $urandom_range(0, 1), $urandom_range(0, 1));
                4: set_order(0, 1, 1, 0, 1, 0);
                default: begin
                    lim = $urandom_range(1, 16);
                    kc  = $urandom_range(0, 3);
                    set_order(lim, kc, $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                end
            endcase
            if (ph == 3) hold_req = 1'b1;
            if (ph == 7) calm = 1'b1;
            sent = 0;
            while (sent < 20) begin
                nrows = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                   : $urandom_range(5, 24);
                for (i = 0; i < nrows; i++) begin
                    send(rand_req(KIND_ADD));
                    sent++;
                end
                send(rand_req(KIND_FINISH));
                sent++;
            end
        end

        guard = 0;
        while (sb.rows_due.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
        if (sb.rows_due.size() != 0) begin
            $display("%0t: %0d expected rows never arrived", $time, sb.rows_due.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
